>>> rtl/packet_mode_packetizer_core_defines.svh
// Assertion macros used by the checker file.
`ifndef PACKET_MODE_PACKETIZER_CORE_DEFINES_SVH
`define PACKET_MODE_PACKETIZER_CORE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PMP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PMP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pmp_pkg.sv
package pmp_pkg;

	// Field widths fixed by the packet format
	localparam int CODE_W   = 2;
	localparam int ADDR_W   = 10;
	localparam int IDX_W    = 7;
	localparam int SIZE_UNIT = 24;
	localparam int HDR_BYTES = 3;
	localparam int TRAILER_BYTES = 5;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Configuration register indexes (byte address bit 2)
	localparam logic REG_SIZE_CODE = 1'b0;
	localparam logic REG_ADDRESS   = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic       store;
		logic       start;
		logic       run;
		logic [1:0] cont;
		logic       first;
	} pmp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic chunk_done;
		logic group_end;
		logic emit_done;
	} pmp_stat_t;

	// Packet length in bytes for a size code
	function automatic logic [IDX_W-1:0] packet_size(input logic [CODE_W-1:0] code);
		return IDX_W'(SIZE_UNIT * (int'(code) + 1));
	endfunction

	// Advance CRC-16-CCITT by one byte, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> rtl/pmp_ctrl.sv
module pmp_ctrl import pmp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  pmp_stat_t stat,
	output pmp_cmd_t  cmd
);

	localparam logic ST_COLLECT = 1'b0;
	localparam logic ST_EMIT    = 1'b1;

	logic       state_q;
	logic [1:0] cont_q;
	logic       first_q;
	logic       accept;

	assign in_ready = (state_q == ST_COLLECT);
	assign accept   = in_valid && in_ready;

	// Drive the datapath
	always_comb begin
		cmd.store = accept;
		cmd.start = accept && stat.chunk_done;
		cmd.run   = (state_q == ST_EMIT);
		cmd.cont  = cont_q;
		cmd.first = first_q;
	end

	// Sequence collect and emit phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			cont_q  <= 2'd0;
			first_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (cmd.start) begin
						state_q <= ST_EMIT;
						cont_q  <= cont_q + 2'd1;
						first_q <= stat.group_end;
					end
				end
				ST_EMIT: begin
					if (stat.emit_done) begin
						state_q <= ST_COLLECT;
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

endmodule

>>> rtl/pmp_datapath.sv
module pmp_datapath import pmp_pkg::*; #(
	parameter int MAX_PACKET_BYTES = 96
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pmp_cmd_t          cmd,
	output pmp_stat_t         stat,
	input  logic [CODE_W-1:0] cfg_code,
	input  logic [ADDR_W-1:0] cfg_addr,
	input  logic [7:0]        data_byte,
	input  logic              end_of_group,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       packet_word,
	output logic              packet_end
);

	localparam int DEPTH = MAX_PACKET_BYTES - TRAILER_BYTES;
	localparam int AW    = $clog2(DEPTH);
	localparam int FW    = $clog2(DEPTH + 1);
	localparam logic [CODE_W-1:0] MAX_CODE = CODE_W'(MAX_PACKET_BYTES / SIZE_UNIT - 1);

	logic [7:0]        store_mem [DEPTH];

	logic [CODE_W-1:0] eff_code;
	logic [FW-1:0]     cap;
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     fill_clamp;
	logic [FW-1:0]     new_fill;
	logic [AW-1:0]     wr_addr;

	logic [23:0]       hdr_q;
	logic [IDX_W-1:0]  len_q;
	logic [IDX_W-1:0]  size_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              fetch_live;
	logic              pay_fetch;
	logic [AW-1:0]     fetch_addr;
	logic              en;

	logic              valid_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [7:0]        rd_s1;

	logic [7:0]        byte_val;
	logic [15:0]       crc_q;
	logic [15:0]       crc_out;
	logic [23:0]       acc_q;
	logic              load;
	logic              last_byte;

	logic              out_valid_q;
	logic [31:0]       out_word_q;
	logic              out_end_q;

	// Clip the size code to what the store can hold
	assign eff_code   = (cfg_code > MAX_CODE) ? MAX_CODE : cfg_code;
	assign cap        = FW'(packet_size(eff_code) - IDX_W'(TRAILER_BYTES));
	assign fill_clamp = (fill_q >= cap) ? (cap - FW'(1)) : fill_q;
	assign new_fill   = fill_clamp + FW'(1);
	assign wr_addr    = AW'(fill_clamp);

	assign stat.chunk_done = (new_fill == cap) || end_of_group;
	assign stat.group_end  = end_of_group;

	// Fetch side of the byte engine
	assign en         = cmd.run && (!out_valid_q || out_ready);
	assign fetch_live = (cnt_q < size_q);
	assign pay_fetch  = (cnt_q >= IDX_W'(HDR_BYTES)) && ((cnt_q - IDX_W'(HDR_BYTES)) < len_q);
	assign fetch_addr = AW'(cnt_q - IDX_W'(HDR_BYTES));

	// Chunk store: write on each beat, read while emitting
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			store_mem[wr_addr] <= data_byte;
		end
		if (en && fetch_live && pay_fetch) begin
			rd_s1 <= store_mem[fetch_addr];
		end
	end

	// Pick the packet byte at the current index
	assign crc_out = ~crc_q;
	always_comb begin
		if (idx_s1 < IDX_W'(HDR_BYTES)) begin
			case (idx_s1[1:0])
				2'd0:    byte_val = hdr_q[23:16];
				2'd1:    byte_val = hdr_q[15:8];
				default: byte_val = hdr_q[7:0];
			endcase
		end else if (idx_s1 == size_q - IDX_W'(2)) begin
			byte_val = crc_out[15:8];
		end else if (idx_s1 == size_q - IDX_W'(1)) begin
			byte_val = crc_out[7:0];
		end else if ((idx_s1 - IDX_W'(HDR_BYTES)) < len_q) begin
			byte_val = rd_s1;
		end else begin
			byte_val = 8'h00;
		end
	end

	assign last_byte      = (idx_s1 == size_q - IDX_W'(1));
	assign load           = en && valid_s1 && (idx_s1[1:0] == 2'd3);
	assign stat.emit_done = en && valid_s1 && last_byte;

	// Chunk fill and packet header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.store) begin
			fill_q <= cmd.start ? '0 : new_fill;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hdr_q  <= {eff_code, cmd.cont, cmd.first, end_of_group, cfg_addr, 1'b0,
				IDX_W'(new_fill)};
			len_q  <= IDX_W'(new_fill);
			size_q <= packet_size(eff_code);
		end
	end

	// Byte engine: advance one byte per enabled cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (cmd.start) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (en) begin
			if (fetch_live) begin
				valid_s1 <= 1'b1;
				cnt_q    <= cnt_q + IDX_W'(1);
			end else begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && fetch_live) begin
			idx_s1 <= cnt_q;
		end
	end

	// Run the CRC and pack bytes into words
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			crc_q <= CRC_INIT;
		end else if (en && valid_s1) begin
			if (idx_s1 < size_q - IDX_W'(2)) begin
				crc_q <= crc_byte(crc_q, byte_val);
			end
			acc_q <= {acc_q[15:0], byte_val};
		end
		if (load) begin
			out_word_q <= {acc_q, byte_val};
			out_end_q  <= last_byte;
		end
	end

	// Output register: hold the word until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign packet_word = out_word_q;
	assign packet_end  = out_end_q;

endmodule

>>> rtl/packet_mode_packetizer_core.sv
// Packet-mode packetizer. Data group bytes enter one per beat with an end-of-group
// flag; a packet of 24*(size code+1) bytes (clipped to MAX_PACKET_BYTES) leaves as
// 32-bit words, earliest byte in bits 31:24, packet_end on the last word. Bytes are
// taken one per cycle while a chunk is collected. Once a chunk closes, the input is
// held off while the packet is built from the chunk store (header, payload,
// padding, CRC), one byte per cycle unless the output is back-pressured. The next
// chunk may start while the last word of a packet waits. Registers: size code at
// 0x0, address at 0x4; write them only while no packet is in flight.
module packet_mode_packetizer_core import pmp_pkg::*; #(
	parameter int MAX_PACKET_BYTES = 96
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_group,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] packet_word,
	output logic        packet_end
);

	logic [CODE_W-1:0] size_code_q;
	logic [ADDR_W-1:0] address_q;
	logic              reg_wr;
	pmp_cmd_t          cmd;
	pmp_stat_t         stat;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_code_q <= '0;
			address_q   <= '0;
		end else if (reg_wr) begin
			unique case (paddr[2])
				REG_SIZE_CODE: size_code_q <= pwdata[CODE_W-1:0];
				REG_ADDRESS:   address_q   <= pwdata[ADDR_W-1:0];
				default:       size_code_q <= size_code_q;
			endcase
		end
	end

	// Read back; unaligned addresses read zero
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'd0) begin
			unique case (paddr[2])
				REG_SIZE_CODE: prdata = {{(32 - CODE_W){1'b0}}, size_code_q};
				REG_ADDRESS:   prdata = {{(32 - ADDR_W){1'b0}}, address_q};
				default:       prdata = '0;
			endcase
		end
	end

	pmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pmp_datapath #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_code     (size_code_q),
		.cfg_addr     (address_q),
		.data_byte    (data_byte),
		.end_of_group (end_of_group),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.packet_word  (packet_word),
		.packet_end   (packet_end)
	);

endmodule

>>> rtl/pmp_checker.sv
`include "packet_mode_packetizer_core_defines.svh"

module pmp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        end_of_group,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] packet_word,
	input logic        packet_end,
	input logic        pready
);

	// A stalled output beat holds its word
	`PMP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(packet_word) && $stable(packet_end), "output beat changed while stalled")

	// No input is taken while a packet is still part-way out
	`PMP_ASSERT(a_no_in_mid_packet, out_valid && !packet_end |-> !in_ready, "input taken mid-packet")

	// The end of a group always closes a chunk
	`PMP_ASSERT(a_group_closes, in_valid && in_ready && end_of_group |=> !in_ready, "group end did not start a packet")

	// The register port never waits
	`PMP_ASSERT_ALWAYS(a_pready, pready, "pready dropped")

endmodule

bind packet_mode_packetizer_core pmp_checker u_pmp_checker (.*);

>>> tb/sv/packet_mode_packetizer_core_tb.sv
`timescale 1ns / 1ps
module packet_mode_packetizer_core_tb;
	import pmp_pkg::*;

	localparam int MAX_BYTES     = 96;
	localparam int SETTLE_CYCLES = 12;
	localparam int TAIL_CYCLES   = 200;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int PHASE_ITEMS   = 24;

	// One 32-bit packet beat as it should leave the block
	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} pkt_beat_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [2:0]  paddr        = '0;
	logic [31:0] pwdata       = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte    = '0;
	logic        end_of_group = 1'b0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [31:0] packet_word;
	logic        packet_end;

	// Shadow of the block's state for prediction
	logic [7:0]   chunk_bytes [0:MAX_BYTES-6];
	int unsigned  chunk_len     = 0;
	logic         first_flag    = 1'b1;
	logic [1:0]   cont_cnt      = 2'd0;
	logic [1:0]   size_code_reg = 2'd0;
	logic [9:0]   addr_reg      = 10'd0;

	pkt_beat_t    expected_beats [$];
	pkt_beat_t    oldest_beat;

	bit           src_idle   = 1'b0;
	bit           sink_idle  = 1'b0;
	int unsigned  sink_wait  = 0;
	int unsigned  err_count  = 0;
	int unsigned  bytes_sent = 0;
	int unsigned  packets_predicted = 0;
	int unsigned  beats_checked = 0;
	int unsigned  cycle_count = 0;

	packet_mode_packetizer_core #(
		.MAX_PACKET_BYTES(MAX_BYTES)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.end_of_group(end_of_group),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.packet_word (packet_word),
		.packet_end  (packet_end)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d beats outstanding", $time, expected_beats.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Size code actually used, lowered until the packet fits the store
	function automatic logic [1:0] used_code();
		logic [1:0] c;
		c = size_code_reg;
		while (c > 0 && 24 * (int'(c) + 1) > MAX_BYTES)
			c--;
		return c;
	endfunction

	// Serial CRC-16-CCITT over one byte, MSB first
	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int k = 7; k >= 0; k--) begin
			fb = c[15] ^ b[k];
			c  = {c[14:0], 1'b0};
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	// Append one beat to the tail of the expected queue
	function automatic void queue_beat(input pkt_beat_t beat);
		expected_beats.insert(expected_beats.size(), beat);
	endfunction

	// Store one byte; on chunk close, queue every beat of the packet
	task automatic predict_byte(input logic [7:0] b, input logic eog);
		logic [1:0]   code;
		int unsigned  frame_len;
		int unsigned  room;
		logic [7:0]   frame [0:MAX_BYTES-1];
		logic [23:0]  hdr;
		logic [15:0]  crc;
		pkt_beat_t    beat;
		code      = used_code();
		frame_len = 24 * (int'(code) + 1);
		room      = frame_len - 5;
		if (chunk_len >= room)
			chunk_len = room - 1;
		chunk_bytes[chunk_len] = b;
		chunk_len++;
		if (chunk_len >= room || eog) begin
			hdr = {code, cont_cnt, first_flag, eog, addr_reg, 1'b0, 7'(chunk_len)};
			for (int i = 0; i < MAX_BYTES; i++)
				frame[i] = 8'h00;
			frame[0] = hdr[23:16];
			frame[1] = hdr[15:8];
			frame[2] = hdr[7:0];
			for (int i = 0; i < int'(chunk_len); i++)
				frame[3 + i] = chunk_bytes[i];
			crc = CRC_INIT;
			for (int i = 0; i < int'(frame_len) - 2; i++)
				crc = crc16_next(crc, frame[i]);
			crc = ~crc;
			frame[frame_len - 2] = crc[15:8];
			frame[frame_len - 1] = crc[7:0];
			for (int w = 0; w < int'(frame_len) / 4; w++) begin
				beat.word = {frame[4*w], frame[4*w+1], frame[4*w+2], frame[4*w+3]};
				beat.last = (w == int'(frame_len) / 4 - 1);
				queue_beat(beat);
			end
			cont_cnt   = cont_cnt + 2'd1;
			first_flag = eog;
			chunk_len  = 0;
			packets_predicted++;
		end
	endtask

	// Check each packet beat and draw the next stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual word %h end %b",
						$time, packet_word, packet_end);
					err_count++;
				end else begin
					oldest_beat = expected_beats.pop_front();
					if (packet_word !== oldest_beat.word) begin
						$display("%0t: packet_word mismatch, expected %h, actual %h",
							$time, oldest_beat.word, packet_word);
						err_count++;
					end
					if (packet_end !== oldest_beat.last) begin
						$display("%0t: packet_end mismatch, expected %b, actual %b",
							$time, oldest_beat.last, packet_end);
						err_count++;
					end
					beats_checked++;
				end
				sink_wait = sink_idle ? $urandom_range(0, 4) : 0;
			end
			if (sink_wait > 0) begin
				out_ready <= 1'b0;
				sink_wait--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one byte and hold it until the beat is taken
	task automatic send_byte(input logic [7:0] b, input logic eog);
		int gap;
		gap = src_idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		data_byte    <= b;
		end_of_group <= eog;
		do @(posedge clk); while (!in_ready);
		predict_byte(b, eog);
		bytes_sent++;
	endtask

	task automatic send_group(input int len);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), i == len - 1);
	endtask

	// Drop valid, wait for every queued beat, then let the block go quiet
	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write a register, then read it back
	task automatic write_reg(input logic reg_sel, input logic [31:0] value);
		logic [31:0] mask;
		mask = (reg_sel == REG_SIZE_CODE) ? 32'h3 : 32'h3FF;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== (value & mask)) begin
			$display("%0t: read-back of register at %h, expected %h, actual %h",
				$time, {reg_sel, 2'b00}, value & mask, prdata);
			err_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (reg_sel == REG_SIZE_CODE)
			size_code_reg = value[1:0];
		else
			addr_reg = value[9:0];
	endtask

	// Reset defaults, byte extremes, one- and two-byte groups, all four continuity values
	task automatic test_single_byte_groups();
		src_idle  = 1'b0;
		sink_idle = 1'b1;
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b1);
		send_byte(8'h3C, 1'b1);
		settle_block();
	endtask

	// Chunk fills on the group's last byte: last flag set, no empty packet
	task automatic test_full_chunk_ends_group();
		write_reg(REG_SIZE_CODE, 32'd0);
		write_reg(REG_ADDRESS, 32'd1023);
		src_idle  = 1'b1;
		sink_idle = 1'b0;
		send_group(19);
		settle_block();
	endtask

	// Shrink the size while a chunk holds more than the new capacity
	task automatic test_size_shrink_mid_chunk();
		write_reg(REG_SIZE_CODE, 32'd1);
		write_reg(REG_ADDRESS, 32'($urandom_range(1, 1022)));
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		for (int i = 0; i < 22; i++)
			send_byte(8'($urandom_range(0, 255)), 1'b0);
		settle_block();
		write_reg(REG_SIZE_CODE, 32'd0);
		send_byte(8'($urandom_range(0, 255)), 1'b1);
		settle_block();
	endtask

	// Random groups over several size and address settings
	task automatic test_random_groups();
		logic [1:0]  phase_code [0:4];
		int unsigned phase_items;
		int          len;
		logic [31:0] addr_val;
		phase_code[0] = 2'd3;
		phase_code[1] = 2'd1;
		phase_code[2] = 2'd0;
		phase_code[3] = 2'd2;
		phase_code[4] = 2'd3;
		for (int p = 0; p < 5; p++) begin
			settle_block();
			addr_val = (p == 0) ? 32'd1023 : (p == 2) ? 32'd0 : 32'($urandom_range(1, 1022));
			write_reg(REG_SIZE_CODE, 32'(phase_code[p]));
			write_reg(REG_ADDRESS, addr_val);
			src_idle  = !(p == 1 || p == 3);
			sink_idle = !(p == 2 || p == 3);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 100)
					: $urandom_range(1, 20);
				send_group(len);
				phase_items += len;
				// now and then hold the source until the packets drain
				if ($urandom_range(0, 9) == 0)
					settle_block();
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_single_byte_groups();
		test_full_chunk_ends_group();
		test_size_shrink_mid_chunk();
		test_random_groups();
		settle_block();
		sink_idle = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_beats.size() != 0) begin
			$display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
			err_count++;
		end
		$display("Sent %0d bytes over all four size codes and both address extremes;",
			bytes_sent);
		$display("checked %0d beats in %0d packets, %0d errors.",
			beats_checked, packets_predicted, err_count);
		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
